/* rtl/spimrb_pkg.sv */
// spimrb_pkg: operation and register codes, control/status bit positions,
// item types and helper functions for the spi master register block.
// no dependencies.
package spimrb_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_CTRL   = 2'd0,
		REG_STATUS = 2'd1,
		REG_DATA   = 2'd2,
		REG_NONE   = 2'd3
	} reg_sel_t;

	// control register bits
	localparam int unsigned CTL_IRQ_EN = 7;
	localparam int unsigned CTL_ENABLE = 6;
	localparam int unsigned CTL_LSB    = 5;
	localparam int unsigned CTL_MASTER = 4;
	localparam int unsigned CTL_POL    = 3;
	localparam int unsigned CTL_PHASE  = 2;

	// status register bits
	localparam int unsigned STS_DONE   = 7;
	localparam int unsigned STS_COLL   = 6;
	localparam int unsigned STS_DOUBLE = 0;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned DIV_W         = 7;
	localparam int unsigned CNT_W         = 4;

	// laid out as on tdata, last field in the low bits
	typedef struct packed {
		logic       miso_in;
		logic [7:0] write_data;
		logic [1:0] reg_select;
	} in_item_t;

	typedef struct packed {
		logic       irq_out;
		logic       mosi_out;
		logic       sck_out;
		logic [7:0] read_data;
	} out_item_t;

	// sck half period in system clocks, indexed by {double_speed, rate}
	function automatic logic [DIV_W-1:0] half_period(input logic [2:0] idx);
		logic [DIV_W-1:0] hp;
		unique case (idx)
			3'd0:    hp = 7'd2;
			3'd1:    hp = 7'd8;
			3'd2:    hp = 7'd32;
			3'd3:    hp = 7'd64;
			3'd4:    hp = 7'd1;
			3'd5:    hp = 7'd4;
			3'd6:    hp = 7'd16;
			default: hp = 7'd32;
		endcase
		return hp;
	endfunction

	function automatic logic [7:0] shift_byte(input logic [7:0] value, input logic lsb_first,
		input logic bit_in);
		return lsb_first ? {bit_in, value[7:1]} : {value[6:0], bit_in};
	endfunction

endpackage

/* rtl/spi_master_register_block.sv */
// spi_master_register_block: spi master with control, status and data registers,
// one register access or one system clock tick per item.
// depends on spimrb_pkg.
//
// channel   dir  tdata (low bit up)                      tuser
// s_axis    in   reg_select[1:0], write_data, miso_in     operation[1:0]
// m_axis    out  read_data, sck_out, mosi_out, irq_out    -
//
// one item per cycle while the skid entry is free; every item gives one registered result item.
// all state is updated at the edge that accepts the item; the result reflects it.
// a two-entry output buffer (output register plus skid) absorbs m_axis stalls;
// s_axis_tready drops only while the skid entry is full.
// arst_n clears all state and both output entries.
module spi_master_register_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // reg_select[1:0], write_data[7:0], miso_in, zero fill
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // read_data[7:0], sck_out, mosi_out, irq_out, zero fill
);
	import spimrb_pkg::*;

	logic [7:0]       ctrl_q, ctrl_d;
	logic             dbl_q, dbl_d;
	logic [7:0]       shift_q, shift_d;
	logic [7:0]       rxbuf_q, rxbuf_d;
	logic [CNT_W-1:0] bitcnt_q, bitcnt_d;
	logic [DIV_W-1:0] divcnt_q, divcnt_d;
	logic             busy_q, busy_d;
	logic             done_q, done_d;
	logic             coll_q, coll_d;
	logic             seen_q, seen_d;
	logic             level_q, level_d;
	logic             sampled_q, sampled_d;

	op_t        op;
	reg_sel_t   sel;
	in_item_t   item;
	out_item_t  res;
	logic       accept;
	logic       phase1;
	logic [DIV_W-1:0] div_inc;
	logic [7:0] rd;

	out_item_t  out_q, skid_q;
	logic       out_vld_q, skid_vld_q;

	assign item   = in_item_t'(s_axis_tdata[10:0]);
	assign op     = op_t'(s_axis_tuser);
	assign sel    = reg_sel_t'(item.reg_select);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign phase1 = ctrl_q[CTL_PHASE];
	assign div_inc = divcnt_q + 7'd1;

	always_comb begin
		ctrl_d    = ctrl_q;
		dbl_d     = dbl_q;
		shift_d   = shift_q;
		rxbuf_d   = rxbuf_q;
		bitcnt_d  = bitcnt_q;
		divcnt_d  = divcnt_q;
		busy_d    = busy_q;
		done_d    = done_q;
		coll_d    = coll_q;
		seen_d    = seen_q;
		level_d   = level_q;
		sampled_d = sampled_q;
		rd        = 8'd0;
		unique case (op)
			OP_READ: begin
				unique case (sel)
					REG_CTRL: rd = ctrl_q;
					REG_STATUS: begin
						rd = 8'd0;
						rd[STS_DONE]   = done_q;
						rd[STS_COLL]   = coll_q;
						rd[STS_DOUBLE] = dbl_q;
						seen_d = done_q || coll_q;
					end
					REG_DATA: begin
						rd = rxbuf_q;
						if (seen_q) begin
							done_d = 1'b0;
							coll_d = 1'b0;
							seen_d = 1'b0;
						end
					end
					default: rd = 8'd0;
				endcase
			end
			OP_WRITE: begin
				unique case (sel)
					REG_CTRL: begin
						ctrl_d = item.write_data;
						if (busy_q && (!item.write_data[CTL_ENABLE] ||
							!item.write_data[CTL_MASTER])) begin
							busy_d   = 1'b0;
							bitcnt_d = '0;
							divcnt_d = '0;
							level_d  = 1'b0;
						end
					end
					REG_STATUS: dbl_d = item.write_data[STS_DOUBLE];
					REG_DATA: begin
						// flag clear comes before the collision of this same write
						if (seen_q) begin
							done_d = 1'b0;
							coll_d = 1'b0;
							seen_d = 1'b0;
						end
						if (busy_q) begin
							coll_d = 1'b1;
						end else begin
							shift_d = item.write_data;
							if (ctrl_q[CTL_ENABLE] && ctrl_q[CTL_MASTER]) begin
								busy_d   = 1'b1;
								bitcnt_d = '0;
								divcnt_d = '0;
								level_d  = 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
			OP_TICK: begin
				if (busy_q) begin
					divcnt_d = div_inc;
					if (div_inc >= half_period({dbl_q, ctrl_q[1:0]})) begin
						divcnt_d = '0;
						if (!level_q) begin
							// leading edge
							level_d = 1'b1;
							if (!phase1)
								sampled_d = item.miso_in;
							else if (bitcnt_q != '0)
								shift_d = shift_byte(shift_q, ctrl_q[CTL_LSB], sampled_q);
						end else begin
							// trailing edge
							level_d = 1'b0;
							if (!phase1)
								shift_d = shift_byte(shift_q, ctrl_q[CTL_LSB], sampled_q);
							else
								sampled_d = item.miso_in;
							bitcnt_d = bitcnt_q + 4'd1;
							if (bitcnt_d >= CNT_W'(BITS_PER_BYTE)) begin
								if (phase1)
									shift_d = shift_byte(shift_d, ctrl_q[CTL_LSB], sampled_d);
								rxbuf_d  = shift_d;
								done_d   = 1'b1;
								busy_d   = 1'b0;
								bitcnt_d = '0;
								divcnt_d = '0;
								level_d  = 1'b0;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.read_data = rd;
		res.sck_out   = ctrl_d[CTL_POL] ^ level_d;
		res.mosi_out  = ctrl_d[CTL_LSB] ? shift_d[0] : shift_d[7];
		res.irq_out   = done_d && ctrl_d[CTL_IRQ_EN];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= '0;
			dbl_q     <= 1'b0;
			shift_q   <= '0;
			rxbuf_q   <= '0;
			bitcnt_q  <= '0;
			divcnt_q  <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			coll_q    <= 1'b0;
			seen_q    <= 1'b0;
			level_q   <= 1'b0;
			sampled_q <= 1'b0;
		end else if (accept) begin
			ctrl_q    <= ctrl_d;
			dbl_q     <= dbl_d;
			shift_q   <= shift_d;
			rxbuf_q   <= rxbuf_d;
			bitcnt_q  <= bitcnt_d;
			divcnt_q  <= divcnt_d;
			busy_q    <= busy_d;
			done_q    <= done_d;
			coll_q    <= coll_d;
			seen_q    <= seen_d;
			level_q   <= level_d;
			sampled_q <= sampled_d;
		end
	end

	// output register plus skid entry
	assign s_axis_tready = !skid_vld_q;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {5'd0, out_q.irq_out, out_q.mosi_out, out_q.sck_out,
		out_q.read_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || m_axis_tready) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= accept;
				end
			end else if (accept) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_axis_tready) begin
			if (skid_vld_q)
				out_q <= skid_q;
			else if (accept)
				out_q <= res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	// the serial clock rests at its idle level and counters are cleared between bytes
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (!level_q && bitcnt_q == '0 && divcnt_q == '0))
		else $error("idle with exchange state left over");

	assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q < CNT_W'(BITS_PER_BYTE))
		else $error("bit count past a byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		divcnt_q < 7'd64)
		else $error("divider count past longest half period");

	assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry full with output register empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op == OP_TICK && !busy_q) |=> ($stable(shift_q) && !busy_q))
		else $error("tick changed state while idle");

endmodule
